### hdl/edist_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance package
// Shared sizes, item codes, word types and the distance saturation helper.
// ----------------------------------------------------------------------------
package edist_pkg;

  localparam int MAX_CHARS = 32;
  localparam int CHAR_W    = 8;
  localparam int DIST_W    = 6;
  localparam int DIST_MAX  = 63;
  localparam int LEN_W     = $clog2(MAX_CHARS + 1);
  localparam int SRC_AW    = $clog2(MAX_CHARS);
  localparam int COL_DEPTH = MAX_CHARS + 1;
  localparam int COL_AW    = $clog2(COL_DEPTH);

  typedef enum logic [1:0] {
    K_START  = 2'd0,
    K_SOURCE = 2'd1,
    K_TARGET = 2'd2,
    K_FINISH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } result_t;

  function automatic logic [DIST_W-1:0] sat_dist(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] s;
    s = v;
    if (LEN_W > DIST_W && v > LEN_W'(DIST_MAX)) s = LEN_W'(DIST_MAX);
    return DIST_W'(s);
  endfunction

endpackage

### hdl/edist_ram.sv
// ----------------------------------------------------------------------------
// Edit distance RAM
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module edist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### hdl/edist_cell.sv
// ----------------------------------------------------------------------------
// Edit distance cell
// One dynamic-programming cell: diagonal on a match, else one plus the minimum.
// ----------------------------------------------------------------------------
module edist_cell
  import edist_pkg::*;
(
  input  logic [LEN_W-1:0] diag,
  input  logic [LEN_W-1:0] up,
  input  logic [LEN_W-1:0] left,
  input  logic             match,
  output logic [LEN_W-1:0] score
);

  logic [LEN_W-1:0] m1;
  logic [LEN_W-1:0] m2;

  always_comb begin
    m1 = (left < up) ? left : up;
    m2 = (m1 < diag) ? m1 : diag;
    score = match ? diag : LEN_W'(m2 + LEN_W'(1));
  end

endmodule

### hdl/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// Edit distance engine
// Stores a source word and sweeps one distance column per target character.
// ----------------------------------------------------------------------------
// Start, source and overflowed words are accepted while busy stays low.
// A target word raises busy for the column sweep, which reads and writes back
//   one column entry per cycle, from entry 0 up to the source length.
// A finish word reads the column memory and shows the result in the cycle after
//   accept, for one cycle, while busy is high; the receiver cannot stall.
// Synchronous reset clears lengths and overflow; memories are not cleared.
module edit_distance_engine
  import edist_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  state_t            state, state_next;
  logic [LEN_W-1:0]  src_len, src_len_next;
  logic [LEN_W-1:0]  tgt_len, tgt_len_next;
  logic              ovf, ovf_next;
  logic [LEN_W-1:0]  idx, idx_next;
  logic [CHAR_W-1:0] chr, chr_next;
  logic              first, first_next;
  logic [LEN_W-1:0]  diag, diag_next;
  logic [LEN_W-1:0]  left, left_next;

  logic              src_we;
  logic [SRC_AW-1:0] src_waddr;
  logic [SRC_AW-1:0] src_raddr;
  logic [CHAR_W-1:0] src_rdata;
  logic              dp_we;
  logic [COL_AW-1:0] dp_waddr;
  logic [LEN_W-1:0]  dp_wdata;
  logic [COL_AW-1:0] dp_raddr;
  logic [LEN_W-1:0]  dp_rdata;

  logic [LEN_W-1:0]  old;
  logic [LEN_W-1:0]  score;
  logic              last;

  edist_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_CHARS)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (item.ch),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  edist_ram #(.WIDTH(LEN_W), .DEPTH(COL_DEPTH)) u_col_ram (
    .clk   (clk),
    .we    (dp_we),
    .waddr (dp_waddr),
    .wdata (dp_wdata),
    .raddr (dp_raddr),
    .rdata (dp_rdata)
  );

  assign old  = first ? idx : dp_rdata;
  assign last = (idx == src_len);

  edist_cell u_cell (
    .diag  (diag),
    .up    (old),
    .left  (left),
    .match (src_rdata == chr),
    .score (score)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      src_len <= '0;
      tgt_len <= '0;
      ovf     <= 1'b0;
    end else begin
      state   <= state_next;
      src_len <= src_len_next;
      tgt_len <= tgt_len_next;
      ovf     <= ovf_next;
    end
    idx   <= idx_next;
    chr   <= chr_next;
    first <= first_next;
    diag  <= diag_next;
    left  <= left_next;
  end

  always_comb begin
    state_next   = state;
    src_len_next = src_len;
    tgt_len_next = tgt_len;
    ovf_next     = ovf;
    idx_next     = idx;
    chr_next     = chr;
    first_next   = first;
    diag_next    = diag;
    left_next    = left;
    src_we       = 1'b0;
    src_waddr    = src_len[SRC_AW-1:0];
    src_raddr    = idx[SRC_AW-1:0];
    dp_we        = 1'b0;
    dp_waddr     = COL_AW'(idx);
    dp_wdata     = score;
    dp_raddr     = COL_AW'(idx);
    done         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (item.kind)
            K_START: begin
              src_len_next = '0;
              tgt_len_next = '0;
              ovf_next     = 1'b0;
            end
            K_SOURCE: begin
              if (tgt_len == '0 && src_len < LEN_W'(MAX_CHARS)) begin
                src_we       = 1'b1;
                src_len_next = LEN_W'(src_len + LEN_W'(1));
              end else begin
                ovf_next = 1'b1;
              end
            end
            K_TARGET: begin
              if (tgt_len < LEN_W'(MAX_CHARS)) begin
                tgt_len_next = LEN_W'(tgt_len + LEN_W'(1));
                first_next   = (tgt_len == '0);
                chr_next     = item.ch;
                idx_next     = '0;
                dp_raddr     = '0;
                state_next   = S_SWEEP;
              end else begin
                ovf_next = 1'b1;
              end
            end
            K_FINISH: begin
              dp_raddr   = COL_AW'(src_len);
              state_next = S_FINISH;
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        dp_we     = 1'b1;
        dp_wdata  = (idx == '0) ? tgt_len : score;
        left_next = dp_wdata;
        diag_next = old;
        idx_next  = LEN_W'(idx + LEN_W'(1));
        dp_raddr  = last ? COL_AW'(idx) : COL_AW'(idx + LEN_W'(1));
        if (last) state_next = S_IDLE;
      end
      S_FINISH: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy            = (state != S_IDLE);
  assign result.distance = sat_dist((tgt_len == '0) ? src_len : dp_rdata);
  assign result.overflow = ovf;

endmodule

### hdl/edist_checker.sv
// ----------------------------------------------------------------------------
// Edit distance checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
module edist_checker
  import edist_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input item_t   item,
  input logic    busy,
  input logic    done,
  input result_t result
);

  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.kind == K_FINISH |=> done)
    else $error("finish word produced no result");

  a_done_from_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && item.kind == K_FINISH))
    else $error("result without a finish word");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result while ready for a new word");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.distance <= DIST_W'(MAX_CHARS))
    else $error("distance beyond word length");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("engine not idle after reset");

endmodule

bind edit_distance_engine edist_checker u_edist_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .done   (done),
  .result (result)
);
